[hdl/packed_entry_word_encoder_unit_macros.svh]
// ------------------------------------------------------------------
// packed entry word encoder assertion macros
// shared concurrent assertion forms for the encoder modules
// ------------------------------------------------------------------
`ifndef PACKED_ENTRY_WORD_ENCODER_UNIT_MACROS_SVH
`define PACKED_ENTRY_WORD_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define PEWEU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("peweu assertion failed");

// next-cycle implication
`define PEWEU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("peweu assertion failed");

`endif

[hdl/peweu_pkg.sv]
// ------------------------------------------------------------------
// peweu_pkg
// types, constants and width tables of the packed entry word encoder
// ------------------------------------------------------------------
`default_nettype none

package peweu_pkg;

   localparam int ENTRIES_PER_SECTION = 4096;
   localparam int POS_W               = $clog2(ENTRIES_PER_SECTION);

   localparam int DIRECT_WIDTH      = 15;
   localparam int MIN_PALETTE_WIDTH = 4;
   localparam int WORD_BITS         = 64;
   localparam int ENTRY_W           = 15;
   localparam int WIDTH_W           = 4;
   localparam int PER_W             = 5;
   localparam int SHIFT_W           = 8;

   localparam int MAX_WORDS = (ENTRIES_PER_SECTION + 3) / 4;
   localparam int WORDS_W   = $clog2(MAX_WORDS + 1);
   localparam int HDR_EXT_W = 28;

   localparam int WORDS_P16 = (ENTRIES_PER_SECTION + 15) / 16;
   localparam int WORDS_P12 = (ENTRIES_PER_SECTION + 11) / 12;
   localparam int WORDS_P10 = (ENTRIES_PER_SECTION + 9) / 10;
   localparam int WORDS_P9  = (ENTRIES_PER_SECTION + 8) / 9;
   localparam int WORDS_P8  = (ENTRIES_PER_SECTION + 7) / 8;
   localparam int WORDS_P7  = (ENTRIES_PER_SECTION + 6) / 7;
   localparam int WORDS_P6  = (ENTRIES_PER_SECTION + 5) / 6;
   localparam int WORDS_P5  = (ENTRIES_PER_SECTION + 4) / 5;
   localparam int WORDS_P4  = (ENTRIES_PER_SECTION + 3) / 4;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_USE_PALETTE  = 2'd0,
      REG_PALETTE_BITS = 2'd1
   } reg_index_type;

   typedef enum logic {
      KIND_HEADER = 1'b0,
      KIND_WORD   = 1'b1
   } kind_type;

   typedef struct packed {
      logic       use_palette;
      logic [3:0] palette_bits;
   } cfg_type;

   typedef struct packed {
      logic                 item_kind;
      logic [WORD_BITS-1:0] payload;
      logic                 section_end;
   } rslt_type;

   typedef struct packed {
      logic [1:0]     count;
      rslt_type [1:0] item;
   } push_type;

   typedef struct packed {
      logic       present;
      logic [7:0] data;
   } hdr_type;

   function automatic logic [WIDTH_W-1:0] entry_width(cfg_type cfg);
      logic [WIDTH_W-1:0] w;
      w = WIDTH_W'(DIRECT_WIDTH);
      if (cfg.use_palette) begin
         w = cfg.palette_bits;
         if (w < WIDTH_W'(MIN_PALETTE_WIDTH)) begin
            w = WIDTH_W'(MIN_PALETTE_WIDTH);
         end
      end
      return w;
   endfunction

   function automatic logic [PER_W-1:0] per_word(logic [WIDTH_W-1:0] w);
      logic [PER_W-1:0] p;
      case (w)
         4'd4:               p = 5'd16;
         4'd5:               p = 5'd12;
         4'd6:               p = 5'd10;
         4'd7:               p = 5'd9;
         4'd8:               p = 5'd8;
         4'd9:               p = 5'd7;
         4'd10:              p = 5'd6;
         4'd11, 4'd12:       p = 5'd5;
         default:            p = 5'd4;
      endcase
      return p;
   endfunction

   function automatic logic [WORDS_W-1:0] word_count(logic [WIDTH_W-1:0] w);
      logic [WORDS_W-1:0] n;
      case (w)
         4'd4:               n = WORDS_W'(WORDS_P16);
         4'd5:               n = WORDS_W'(WORDS_P12);
         4'd6:               n = WORDS_W'(WORDS_P10);
         4'd7:               n = WORDS_W'(WORDS_P9);
         4'd8:               n = WORDS_W'(WORDS_P8);
         4'd9:               n = WORDS_W'(WORDS_P7);
         4'd10:              n = WORDS_W'(WORDS_P6);
         4'd11, 4'd12:       n = WORDS_W'(WORDS_P5);
         default:            n = WORDS_W'(WORDS_P4);
      endcase
      return n;
   endfunction

   // leb128 byte number idx of the word count
   function automatic hdr_type header_byte(logic [WORDS_W-1:0] words, logic [1:0] idx);
      logic [HDR_EXT_W-1:0] ext;
      logic [HDR_EXT_W-1:0] grp;
      hdr_type              h;
      ext = HDR_EXT_W'(words);
      case (idx)
         2'd0:    grp = ext;
         2'd1:    grp = ext >> 7;
         2'd2:    grp = ext >> 14;
         default: grp = ext >> 21;
      endcase
      h.present = (idx == 2'd0) || (grp != '0);
      h.data    = {(grp >= HDR_EXT_W'(8'h80)), grp[6:0]};
      return h;
   endfunction

endpackage

`default_nettype wire

[hdl/peweu_pack.sv]
// ------------------------------------------------------------------
// peweu_pack
// input register, entry packing and header byte generation
// ------------------------------------------------------------------
`default_nettype none
`include "packed_entry_word_encoder_unit_macros.svh"

module peweu_pack (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire peweu_pkg::cfg_type            cfg,
   input  wire logic                          take,
   input  wire logic [peweu_pkg::ENTRY_W-1:0] entry_value,
   output peweu_pkg::push_type                push
);
   import peweu_pkg::*;

   logic                 stage_valid_ff;
   logic [ENTRY_W-1:0]   entry_ff;
   logic [WORD_BITS-1:0] acc_ff,  acc_in;
   logic [3:0]           slot_ff, slot_in;
   logic [POS_W-1:0]     pos_ff,  pos_in;

   logic [WIDTH_W-1:0]   w;
   logic [PER_W-1:0]     per;
   logic [WORDS_W-1:0]   words;
   hdr_type              hdr0, hdr1;
   logic                 first, last, h0, h1, emit_word, fit;
   logic [SHIFT_W-1:0]   shift;
   logic [ENTRY_W-1:0]   masked;
   logic [WORD_BITS-1:0] word_val;
   rslt_type             word_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= take;
      end
      if (take) begin
         entry_ff <= entry_value;
      end
   end

   always_comb begin
      w      = entry_width(cfg);
      per    = per_word(w);
      words  = word_count(w);
      first  = pos_ff < POS_W'(2);
      last   = pos_ff == POS_W'(ENTRIES_PER_SECTION - 1);
      hdr0   = header_byte(words, {pos_ff[0], 1'b0});
      hdr1   = header_byte(words, {pos_ff[0], 1'b1});
      h0     = stage_valid_ff && first && hdr0.present;
      h1     = stage_valid_ff && first && hdr1.present;

      shift  = SHIFT_W'(slot_ff) * SHIFT_W'(w);
      fit    = ((SHIFT_W + 1)'(shift) + (SHIFT_W + 1)'(w)) <= (SHIFT_W + 1)'(WORD_BITS);
      masked = entry_ff & ((ENTRY_W'(1) << w) - ENTRY_W'(1));
      word_val = acc_ff;
      if (fit) begin
         word_val = acc_ff | (WORD_BITS'(masked) << shift[5:0]);
      end
      emit_word = stage_valid_ff && (((PER_W'(slot_ff) + PER_W'(1)) >= per) || last);

      word_item.item_kind   = KIND_WORD;
      word_item.payload     = word_val;
      word_item.section_end = last;
   end

   // results in stream order: header bytes, then the word
   always_comb begin
      push = '0;
      if (h0) begin
         push.item[0].item_kind = KIND_HEADER;
         push.item[0].payload   = WORD_BITS'(hdr0.data);
      end
      if (h1) begin
         push.item[h0].item_kind = KIND_HEADER;
         push.item[h0].payload   = WORD_BITS'(hdr1.data);
      end
      if (emit_word) begin
         push.item[h0 | h1] = word_item;
      end
      push.count = 2'(h0) + 2'(h1) + 2'(emit_word);
   end

   always_comb begin
      acc_in  = acc_ff;
      slot_in = slot_ff;
      pos_in  = pos_ff;
      if (stage_valid_ff) begin
         if (emit_word) begin
            acc_in  = '0;
            slot_in = '0;
         end else begin
            acc_in  = word_val;
            slot_in = slot_ff + 4'd1;
         end
         pos_in = last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         slot_ff <= '0;
         pos_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         slot_ff <= slot_in;
         pos_ff  <= pos_in;
      end
   end

   `PEWEU_ASSERT_NXT(a_section_wrap, clock, reset, stage_valid_ff && last, (pos_ff == '0) && (slot_ff == '0) && (acc_ff == '0))
   `PEWEU_ASSERT_IMP(a_no_word_at_start, clock, reset, stage_valid_ff && (pos_ff == '0), !emit_word)
   `PEWEU_ASSERT_NXT(a_slot_advance, clock, reset, stage_valid_ff && !emit_word, slot_ff == 4'($past(slot_ff) + 4'd1))

endmodule

`default_nettype wire

[hdl/peweu_rsp_queue.sv]
// ------------------------------------------------------------------
// peweu_rsp_queue
// small result queue, up to two pushes and one pop per cycle
// ------------------------------------------------------------------
`default_nettype none
`include "packed_entry_word_encoder_unit_macros.svh"

module peweu_rsp_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire peweu_pkg::push_type               push,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output peweu_pkg::rslt_type                    rsp_item,
   output logic [peweu_pkg::Q_CNT_W-1:0]          count
);
   import peweu_pkg::*;

   rslt_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in;
   logic [Q_PTR_W-1:0]   rd_ff, rd_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 pop;

   always_comb begin
      rsp_valid = count_ff != '0;
      rsp_item  = mem_ff[rd_ff];
      count     = count_ff;
      pop       = rsp_valid && !rsp_stall;
      wr_in     = wr_ff + Q_PTR_W'(push.count);
      rd_in     = rd_ff + Q_PTR_W'(pop);
      count_in  = count_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + Q_PTR_W'(1)] <= push.item[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `PEWEU_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))
   `PEWEU_ASSERT_IMP(a_no_overflow, clock, reset, push.count != 2'd0, (4'(count_ff) + 4'(push.count)) <= (4'(Q_DEPTH) + 4'(pop)))
   `PEWEU_ASSERT_NXT(a_drain_empty, clock, reset, pop && (count_ff == Q_CNT_W'(1)) && (push.count == 2'd0), !rsp_valid)

endmodule

`default_nettype wire

[hdl/packed_entry_word_encoder_unit.sv]
// ------------------------------------------------------------------
// packed_entry_word_encoder_unit
// packs section entries into 64-bit words with a leb128 word-count header
// ------------------------------------------------------------------
// req channel: one entry value per transaction, a section of 4096 in order.
// rsp channel: header bytes (item_kind 0) and packed words (item_kind 1);
//   the last word of a section carries section_end.
// csr channel: index 0 use_palette, index 1 palette_bits; csr_ready is
//   always high; the user must write only while the block is idle (unchecked).
// path: an accepted entry is captured in the input register, its results
//   are then written into the result queue, and from the queue they are
//   presented on the rsp ports.
// throughput: one entry per cycle (req_stall low); each entry gives at
//   most one word and only the first entry of a section adds two header
//   bytes, so the one-pop-per-cycle queue keeps up with rsp_stall low.
// stall: req_stall rises once the 4-entry queue, counting the results of
//   the entry in the input register, has fewer than two free places;
//   rsp payload holds while rsp_stall is high.
// reset: config returns to direct 15-bit mode, section position, slot and
//   accumulator clear, the queue empties.
// ------------------------------------------------------------------
`default_nettype none

module packed_entry_word_encoder_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [peweu_pkg::ENTRY_W-1:0]     req_entry_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_item_kind,
   output logic [peweu_pkg::WORD_BITS-1:0]        rsp_payload,
   output logic                                   rsp_section_end,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [peweu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [peweu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import peweu_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   push_type             push;
   rslt_type             rsp_item;
   logic [Q_CNT_W-1:0]   q_count;
   logic                 take;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_USE_PALETTE:  cfg_in.use_palette  = csr_wdata[0];
            REG_PALETTE_BITS: cfg_in.palette_bits = csr_wdata[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_stall = (4'(q_count) + 4'(push.count)) > 4'(Q_DEPTH - 2);
      take      = req_valid && !req_stall;
      rsp_item_kind   = rsp_item.item_kind;
      rsp_payload     = rsp_item.payload;
      rsp_section_end = rsp_item.section_end;
   end

   peweu_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (take),
      .entry_value (req_entry_value),
      .push        (push)
   );

   peweu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .count     (q_count)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// tb_top
// Self-checking testbench for packed_entry_word_encoder_unit.
// Entries are streamed into the encoder while an in-bench model packs
// them into 64-bit words and the leb128 word-count header bytes. Every
// response transaction is compared field by field with the oldest
// predicted one. Directed tests cover the header, width limits, value
// masking and width changes in the middle of a word. Random phases
// follow, with mode changes while the unit is idle; the first adds
// random request gaps and rsp_stall bursts, the second has neither.
// ------------------------------------------------------------------

module tb_top;
   import peweu_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ENTRY_W-1:0]     req_entry_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_item_kind;
   logic [WORD_BITS-1:0]   rsp_payload;
   logic                   rsp_section_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // packing model state
   logic                 mode_palette;
   logic [3:0]           mode_palette_bits;
   logic [WORD_BITS-1:0] packed_word;
   int                   word_slot;
   int                   section_pos;

   rslt_type pending_items[$];
   rslt_type head_item;
   int       error_count;
   int       idle_cycles;
   bit       idling_on;

   packed_entry_word_encoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_payload     (rsp_payload),
      .rsp_section_end (rsp_section_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void push_item(logic kind, logic [WORD_BITS-1:0] data, logic last);
      rslt_type item;
      item.item_kind   = kind;
      item.payload     = data;
      item.section_end = last;
      pending_items.push_back(item);
   endfunction

   // leb128 byte idx of the section word count, queued when it exists
   function automatic void push_count_byte(int idx, int per);
      int words;
      words = (ENTRIES_PER_SECTION + per - 1) / per;
      for (int i = 0; i < idx; i++) begin
         if (words < 'h80) begin
            return;
         end
         words = words >> 7;
      end
      if (words < 'h80) begin
         push_item(KIND_HEADER, 64'(words), 1'b0);
      end else begin
         push_item(KIND_HEADER, 64'((words & 'h7F) | 'h80), 1'b0);
      end
   endfunction

   function automatic void pack_entry(logic [ENTRY_W-1:0] value);
      int                   width;
      int                   per;
      int                   shift;
      logic [WORD_BITS-1:0] masked;
      bit                   last;
      width = DIRECT_WIDTH;
      if (mode_palette) begin
         width = (mode_palette_bits < MIN_PALETTE_WIDTH) ? MIN_PALETTE_WIDTH
                                                         : int'(mode_palette_bits);
      end
      per    = WORD_BITS / width;
      shift  = word_slot * width;
      masked = 64'(value) & ((64'd1 << width) - 64'd1);
      last   = (section_pos >= ENTRIES_PER_SECTION - 1);
      if (section_pos < 2) begin
         push_count_byte(section_pos * 2, per);
         push_count_byte(section_pos * 2 + 1, per);
      end
      if (shift + width <= WORD_BITS) begin
         packed_word = packed_word | (masked << shift);
      end
      if (word_slot + 1 >= per || last) begin
         push_item(KIND_WORD, packed_word, last);
         packed_word = '0;
         word_slot   = 0;
      end else begin
         word_slot = (word_slot + 1) & 15;
      end
      if (last) begin
         section_pos = 0;
         packed_word = '0;
         word_slot   = 0;
      end else begin
         section_pos++;
      end
   endfunction

   function automatic logic [ENTRY_W-1:0] random_entry();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return ENTRY_W'($urandom_range(0, 32767));
      endcase
   endfunction

   task automatic send_entry(input logic [ENTRY_W-1:0] value);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_entry_value <= value;
      do @(negedge clock); while (req_stall);
      pack_entry(value);
      @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      case (idx)
         REG_USE_PALETTE:  mode_palette = data[0];
         REG_PALETTE_BITS: mode_palette_bits = data;
         default: ;
      endcase
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic palette, input logic [3:0] bits);
      write_reg(REG_USE_PALETTE, CSR_DATA_W'(palette));
      write_reg(REG_PALETTE_BITS, bits);
   endtask

   // sender holds off until the unit has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_items.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_random_mode();
      case ($urandom_range(0, 5))
         0:       set_mode(1'b0, 4'($urandom_range(0, 15)));
         1:       set_mode(1'b1, 4'd0);
         2:       set_mode(1'b1, 4'd15);
         3:       set_mode(1'b1, 4'd8);
         default: set_mode(1'b1, 4'($urandom_range(0, 15)));
      endcase
   endtask

   task automatic test_direct_header();
      send_entry('1);
      send_entry('0);
      send_entry('1);
      send_entry(15'h2AAA);
   endtask

   task automatic test_palette_min_width();
      wait_idle();
      set_mode(1'b1, 4'd0);
      send_entry('1);
      send_entry(15'h0005);
      send_entry('0);
      send_entry(15'h7FF0);
      send_entry(15'h000A);
      send_entry('1);
   endtask

   // word slot already past what a 15-bit word holds
   task automatic test_width_change_mid_word();
      wait_idle();
      set_mode(1'b0, 4'd8);
      send_entry('1);
   endtask

   task automatic test_wide_palette();
      wait_idle();
      set_mode(1'b1, 4'd15);
      send_entry('1);
      send_entry(15'h5555);
      send_entry('0);
      send_entry(15'h2AAA);
      wait_idle();
      set_mode(1'b1, 4'd8);
      for (int i = 0; i < 8; i++) begin
         send_entry((i % 2 == 0) ? 15'h7FFF : 15'h0F00);
      end
   endtask

   task automatic test_random_traffic(input int total);
      int sent;
      int len;
      sent = 0;
      while (sent < total) begin
         wait_idle();
         set_random_mode();
         len = $urandom_range(10, 120);
         if (len > total - sent) begin
            len = total - sent;
         end
         repeat (len) send_entry(random_entry());
         sent += len;
      end
   endtask

   // response side stall bursts
   initial begin
      int unsigned burst;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 30) == 0) begin
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_items.size() == 0) begin
            if (error_count < MAX_REPORTS) begin
               $display("unexpected transaction: kind %0b payload %h end %0b",
                        rsp_item_kind, rsp_payload, rsp_section_end);
            end
            error_count++;
         end else begin
            head_item = pending_items.pop_front();
            if (head_item.item_kind !== rsp_item_kind
                || head_item.payload !== rsp_payload
                || head_item.section_end !== rsp_section_end) begin
               if (error_count < MAX_REPORTS) begin
                  $display("mismatch: expected kind %0b payload %h end %0b, got %0b %h %0b",
                           head_item.item_kind, head_item.payload, head_item.section_end,
                           rsp_item_kind, rsp_payload, rsp_section_end);
               end
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d transactions outstanding",
                  pending_items.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      mode_palette      = 1'b0;
      mode_palette_bits = '0;
      packed_word       = '0;
      word_slot         = 0;
      section_pos       = 0;
      error_count       = 0;
      idle_cycles       = 0;
      idling_on         = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_direct_header();
      test_palette_min_width();
      test_width_change_mid_word();
      test_wide_palette();
      test_random_traffic(700);
      wait_idle();
      idling_on = 1'b0;
      test_random_traffic(150);

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_items.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
